// ===== hw/rtl/itad_pkg.sv =====
// Shared types, constants and helper functions of the integer to ASCII digits unit.
package itad_pkg;

	// Port field widths
	localparam int unsigned VALUE_W_MAX   = 64;
	localparam int unsigned VALUE_W_DEF   = 64;
	localparam int unsigned CHAR_W        = 7;
	localparam int unsigned S_TDATA_W     = 64;
	localparam int unsigned M_TDATA_W     = 8;

	// Character codes
	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_X      = 7'h78;
	localparam logic [CHAR_W-1:0] ALPHA_OFS   = 7'd55;

	// Radix command codes
	localparam logic CMD_DEC = 1'b0;
	localparam logic CMD_HEX = 1'b1;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DABBLE,
		ST_SCAN,
		ST_PFX0,
		ST_PFX1,
		ST_DIGIT
	} conv_state_t;

	// Add three to a BCD digit of five or more before it is doubled
	function automatic logic [3:0] dd_adjust(input logic [3:0] d);
		logic [3:0] r;
		r = (d >= 4'd5) ? (d + 4'd3) : d;
		return r;
	endfunction

	// Map a digit value to its upper-case ASCII character
	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		logic [CHAR_W-1:0] c;
		c = (d > 4'd9) ? (CHAR_W'(d) + ALPHA_OFS) : (CHAR_W'(d) + CHAR_ZERO);
		return c;
	endfunction

endpackage

// ===== hw/rtl/integer_to_ascii_digits_unit.sv =====
// Top level of the integer to ASCII digits unit: front queue and converting back end.
// A decimal request is converted by the bit-serial BCD shift, one value bit a cycle; a hex
// request loads its digits straight from the value. The leading-zero scan then skips the
// zero digits above the first nonzero one; characters leave through one output register,
// one a cycle while the output is ready. Two requests queue ahead; reset empties both parts.
module integer_to_ascii_digits_unit #(
	parameter int unsigned VALUE_WIDTH = itad_pkg::VALUE_W_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic                           s_tuser,   // [0] command
	input  logic [itad_pkg::S_TDATA_W-1:0] s_tdata,   // [63:0] value
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [itad_pkg::M_TDATA_W-1:0] m_tdata,   // [6:0] character, [7] zero
	output logic                           m_tlast
);

	logic                        q_valid;
	logic                        q_cmd;
	logic [VALUE_WIDTH-1:0]      q_value;
	logic                        q_pop;
	logic [itad_pkg::CHAR_W-1:0] out_char;

	// Accept and queue requests
	itad_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_value  (q_value),
		.q_pop    (q_pop)
	);

	// Convert and stream characters
	itad_conv #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_value   (q_value),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (out_char),
		.out_last  (m_tlast)
	);

	assign m_tdata = itad_pkg::M_TDATA_W'(out_char);

endmodule

// ===== hw/rtl/itad_front.sv =====
// Front end: accepts requests, trims the value and holds them in a two-entry queue.
module itad_front #(
	parameter int unsigned VALUE_WIDTH = itad_pkg::VALUE_W_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic                           s_tuser,   // [0] command
	input  logic [itad_pkg::S_TDATA_W-1:0] s_tdata,   // [63:0] value
	output logic                           q_valid,
	output logic                           q_cmd,
	output logic [VALUE_WIDTH-1:0]         q_value,
	input  logic                           q_pop
);

	localparam int unsigned ENT_W = VALUE_WIDTH + 1;

	logic [ENT_W-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_pop && q_valid;

	// Present the oldest request
	assign q_cmd   = mem_q[rd_ptr_q][ENT_W-1];
	assign q_value = mem_q[rd_ptr_q][VALUE_WIDTH-1:0];

	// Store request payload, dropping value bits above the configured width
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= {s_tuser, s_tdata[VALUE_WIDTH-1:0]};
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue occupancy out of range");

	a_full_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
		else $error("full queue lost an entry");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");
`endif

endmodule

// ===== hw/rtl/itad_conv.sv =====
// Back end: converts one queued request to digits and streams the ASCII characters.
module itad_conv #(
	parameter int unsigned VALUE_WIDTH = itad_pkg::VALUE_W_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	input  logic                             q_cmd,
	input  logic [VALUE_WIDTH-1:0]           q_value,
	output logic                             q_pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [itad_pkg::CHAR_W-1:0]      out_char,
	output logic                             out_last
);

	localparam int unsigned NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int unsigned HEXD = (VALUE_WIDTH + 3) / 4;
	localparam int unsigned IDXW = $clog2(NDIG);
	localparam int unsigned BCW  = $clog2(VALUE_WIDTH + 1);

	itad_pkg::conv_state_t state_q;
	itad_pkg::conv_state_t state_d;

	logic                        cmd_q;
	logic [VALUE_WIDTH-1:0]      shift_q;
	logic [BCW-1:0]              bitcnt_q;
	logic [3:0]                  digit_q [NDIG];
	logic [3:0]                  adj     [NDIG];
	logic [IDXW-1:0]             idx_q;
	logic [4*HEXD-1:0]           hex_pad;

	logic                        out_valid_q;
	logic [itad_pkg::CHAR_W-1:0] out_char_q;
	logic                        out_last_q;
	logic                        out_free;
	logic                        out_load;
	logic [itad_pkg::CHAR_W-1:0] char_d;
	logic                        last_d;
	logic                        cur_zero;

	assign out_free = !out_valid_q || out_ready;
	assign hex_pad  = (4*HEXD)'(q_value);
	assign cur_zero = (digit_q[idx_q] == 4'd0);

	// Correct each BCD digit ahead of the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = itad_pkg::dd_adjust(digit_q[i]);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			itad_pkg::ST_IDLE: begin
				if (q_valid) begin
					state_d = (q_cmd == itad_pkg::CMD_HEX) ? itad_pkg::ST_SCAN
					                                      : itad_pkg::ST_DABBLE;
				end
			end
			itad_pkg::ST_DABBLE: begin
				if (bitcnt_q == BCW'(1)) begin
					state_d = itad_pkg::ST_SCAN;
				end
			end
			itad_pkg::ST_SCAN: begin
				if (!cur_zero || idx_q == '0) begin
					state_d = (cmd_q == itad_pkg::CMD_HEX) ? itad_pkg::ST_PFX0
					                                      : itad_pkg::ST_DIGIT;
				end
			end
			itad_pkg::ST_PFX0: begin
				if (out_free) begin
					state_d = itad_pkg::ST_PFX1;
				end
			end
			itad_pkg::ST_PFX1: begin
				if (out_free) begin
					state_d = itad_pkg::ST_DIGIT;
				end
			end
			itad_pkg::ST_DIGIT: begin
				if (out_free && idx_q == '0) begin
					state_d = itad_pkg::ST_IDLE;
				end
			end
			default: state_d = itad_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		q_pop    = 1'b0;
		out_load = 1'b0;
		char_d   = itad_pkg::CHAR_ZERO;
		last_d   = 1'b0;
		case (state_q)
			itad_pkg::ST_IDLE: begin
				q_pop = q_valid;
			end
			itad_pkg::ST_PFX0: begin
				out_load = out_free;
				char_d   = itad_pkg::CHAR_ZERO;
			end
			itad_pkg::ST_PFX1: begin
				out_load = out_free;
				char_d   = itad_pkg::CHAR_X;
			end
			itad_pkg::ST_DIGIT: begin
				out_load = out_free;
				char_d   = itad_pkg::digit_char(digit_q[idx_q]);
				last_d   = (idx_q == '0);
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itad_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			bitcnt_q    <= '0;
			idx_q       <= '0;
			cmd_q       <= itad_pkg::CMD_DEC;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				itad_pkg::ST_IDLE: begin
					if (q_valid) begin
						cmd_q    <= q_cmd;
						bitcnt_q <= BCW'(VALUE_WIDTH);
						idx_q    <= (q_cmd == itad_pkg::CMD_HEX) ? IDXW'(HEXD - 1)
						                                         : IDXW'(NDIG - 1);
					end
				end
				itad_pkg::ST_DABBLE: begin
					bitcnt_q <= bitcnt_q - BCW'(1);
				end
				itad_pkg::ST_SCAN: begin
					if (cur_zero && idx_q != '0) begin
						idx_q <= idx_q - IDXW'(1);
					end
				end
				itad_pkg::ST_DIGIT: begin
					if (out_free && idx_q != '0) begin
						idx_q <= idx_q - IDXW'(1);
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// Load digits, or shift the value into the BCD digits one bit a cycle
	always_ff @(posedge clk) begin
		if (state_q == itad_pkg::ST_IDLE && q_valid) begin
			shift_q <= q_value;
			for (int i = 0; i < NDIG; i++) begin
				if (q_cmd == itad_pkg::CMD_HEX && i < HEXD) begin
					digit_q[i] <= hex_pad[4*i +: 4];
				end else begin
					digit_q[i] <= 4'd0;
				end
			end
		end else if (state_q == itad_pkg::ST_DABBLE) begin
			shift_q <= shift_q << 1;
			digit_q[0] <= {adj[0][2:0], shift_q[VALUE_WIDTH-1]};
			for (int i = 1; i < NDIG; i++) begin
				digit_q[i] <= {adj[i][2:0], adj[i-1][3]};
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q <= char_d;
			out_last_q <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == itad_pkg::ST_IDLE && q_valid))
		else $error("request taken outside idle");

	a_dabble_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itad_pkg::ST_DABBLE) |-> (bitcnt_q != '0))
		else $error("bit counter ran out while converting");

	a_prefix_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itad_pkg::ST_PFX0 && out_free) |=>
		(state_q == itad_pkg::ST_PFX1 && out_valid_q && out_char_q == itad_pkg::CHAR_ZERO))
		else $error("prefix sequence broken");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_d) |=> (state_q == itad_pkg::ST_IDLE && out_last_q))
		else $error("final character did not end the conversion");
`endif

endmodule

// ===== verif/tb_integer_to_ascii_digits_unit.sv =====
// Self-checking testbench of the integer to ASCII digits unit: directed and random requests.
module tb_integer_to_ascii_digits_unit;

	localparam int unsigned VAL_W        = itad_pkg::VALUE_W_DEF;
	localparam int unsigned MAX_CHARS    = 20;
	localparam int unsigned RANDOM_REQS  = 200;
	localparam int unsigned CALM_REQS    = 40;
	localparam int unsigned DRAIN_CYCLES = 24;

	// One expected output character and its end-of-string mark
	typedef struct packed {
		logic [itad_pkg::CHAR_W-1:0] ch;
		logic                        lst;
	} char_exp_t;

	// Predicts the character string of each request and checks the output against it
	class digit_scoreboard;
		char_exp_t   want_q[$];
		int unsigned n_requests;
		int unsigned n_hex;
		int unsigned n_chars;

		function new();
			n_requests = 0;
			n_hex      = 0;
			n_chars    = 0;
		endfunction

		// Expand one accepted request into its expected characters
		function void note_request(input logic cmd, input logic [63:0] value);
			logic [3:0]  digits [MAX_CHARS];
			logic [63:0] rest;
			logic [63:0] radix;
			logic [3:0]  d;
			int          cnt;
			int          emitted;
			char_exp_t   e;
			n_requests++;
			radix = (cmd == itad_pkg::CMD_HEX) ? 64'd16 : 64'd10;
			rest  = value & ({64{1'b1}} >> (64 - VAL_W));
			cnt   = 0;
			// Collect digits least significant first, always at least one
			do begin
				if (cnt < MAX_CHARS) begin
					digits[cnt] = 4'(rest % radix);
					cnt++;
				end
				rest = rest / radix;
			end while (rest != 0);
			emitted = 0;
			if (cmd == itad_pkg::CMD_HEX) begin
				n_hex++;
				e.ch  = itad_pkg::CHAR_ZERO;
				e.lst = 1'b0;
				want_q.push_back(e);
				e.ch  = itad_pkg::CHAR_X;
				want_q.push_back(e);
				emitted = 2;
			end
			// Emit most significant first, upper-case letters above nine
			for (int i = cnt - 1; i >= 0 && emitted < MAX_CHARS; i--) begin
				d     = digits[i];
				e.ch  = (d > 4'd9) ? (itad_pkg::CHAR_W'(d) + itad_pkg::ALPHA_OFS)
				                   : (itad_pkg::CHAR_W'(d) + itad_pkg::CHAR_ZERO);
				e.lst = (i == 0);
				want_q.push_back(e);
				emitted++;
			end
		endfunction

		// Compare one output character with the oldest expectation
		function bit check_char(input logic [itad_pkg::CHAR_W-1:0] ch, input logic lst,
			output string why);
			char_exp_t e;
			why = "";
			if (want_q.size() == 0) begin
				why = $sformatf("unexpected character 0x%02h last=%0b", ch, lst);
				return 1'b0;
			end
			e = want_q.pop_front();
			n_chars++;
			if (ch !== e.ch || lst !== e.lst) begin
				why = $sformatf("character %0d: got 0x%02h last=%0b, want 0x%02h last=%0b",
					n_chars, ch, lst, e.ch, e.lst);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function int unsigned pending();
			return want_q.size();
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic                           s_tuser;   // [0] command
	logic [itad_pkg::S_TDATA_W-1:0] s_tdata;   // [63:0] value
	logic                           m_tvalid;
	logic                           m_tready;
	logic [itad_pkg::M_TDATA_W-1:0] m_tdata;   // [6:0] character, [7] zero
	logic                           m_tlast;

	digit_scoreboard sb;
	int unsigned     mismatches = 0;
	bit              calm = 1'b0;
	string           why;

	integer_to_ascii_digits_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Clock: period of two units
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Note accepted requests and check accepted characters on the pre-edge values
	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (!sb.check_char(m_tdata[itad_pkg::CHAR_W-1:0], m_tlast, why))
					report_mismatch(why);
			end
		end
	end

	// Present one request, with an optional idle burst first; return at its acceptance edge
	task automatic send_request(input logic cmd, input logic [63:0] val);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			s_tuser  <= 1'($urandom_range(0, 1));
			s_tdata  <= {$urandom, $urandom};
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= val;
		do @(posedge clk); while (!s_tready);
	endtask

	// Spread values over all digit counts, with boundaries of powers of ten
	function automatic logic [63:0] pick_value();
		logic [63:0] v;
		case ($urandom_range(0, 3))
			0: v = {$urandom, $urandom};
			1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
			2: v = 64'($urandom_range(0, 1000));
			default: begin
				v = 64'd1;
				repeat ($urandom_range(0, 19)) v = v * 64'd10;
				v = v + 64'($urandom_range(0, 2)) - 64'd1;
			end
		endcase
		return v;
	endfunction

	// Stall the character output in bursts, never during the calm part
	initial begin
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Main sequence: reset, directed requests, random requests, drain
	initial begin
		sb = new();
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= itad_pkg::CMD_DEC;
		s_tdata  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Zero, widest values, digit and prefix boundaries
		send_request(itad_pkg::CMD_DEC, 64'd0);
		send_request(itad_pkg::CMD_HEX, 64'd0);
		send_request(itad_pkg::CMD_DEC, {64{1'b1}});
		send_request(itad_pkg::CMD_HEX, {64{1'b1}});
		send_request(itad_pkg::CMD_DEC, 64'd1);
		send_request(itad_pkg::CMD_HEX, 64'd1);
		send_request(itad_pkg::CMD_DEC, 64'd9);
		send_request(itad_pkg::CMD_DEC, 64'd10);
		send_request(itad_pkg::CMD_HEX, 64'd15);
		send_request(itad_pkg::CMD_HEX, 64'd16);
		send_request(itad_pkg::CMD_DEC, 64'd99);
		send_request(itad_pkg::CMD_DEC, 64'd100);
		send_request(itad_pkg::CMD_DEC, 64'd9999999999999999999);
		send_request(itad_pkg::CMD_DEC, 64'd10000000000000000000);
		send_request(itad_pkg::CMD_HEX, 64'h0123456789ABCDEF);
		send_request(itad_pkg::CMD_HEX, 64'hFEDCBA9876543210);
		send_request(itad_pkg::CMD_DEC, 64'h8000000000000000);
		send_request(itad_pkg::CMD_HEX, 64'hAAAAAAAAAAAAAAAA);
		send_request(itad_pkg::CMD_DEC, 64'h5555555555555555);
		send_request(itad_pkg::CMD_HEX, 64'hA);

		// Random requests; the last stretch runs without idling
		for (int unsigned k = 0; k < RANDOM_REQS; k++) begin
			if (k >= RANDOM_REQS - CALM_REQS)
				calm = 1'b1;
			send_request(1'($urandom_range(0, 1)), pick_value());
		end
		s_tvalid <= 1'b0;

		// Drain every expected character, then watch for strays
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d requests (%0d hexadecimal), %0d characters checked.",
			sb.n_requests, sb.n_hex, sb.n_chars);
		$display("Mismatches seen: %0d", mismatches);
		if (mismatches == 0)
			$display("integer_to_ascii_digits_unit verification clean");
		else
			$display("integer_to_ascii_digits_unit verification failed");
		$finish;
	end

	// Watchdog: end a hung run
	initial begin
		#600000;
		$display("Timeout with %0d characters still expected", sb.pending());
		$display("integer_to_ascii_digits_unit verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/itad_pkg.sv
hw/rtl/itad_front.sv
hw/rtl/itad_conv.sv
hw/rtl/integer_to_ascii_digits_unit.sv
verif/tb_integer_to_ascii_digits_unit.sv
